/* rtl/mf3_pkg.sv */
// Shared types, constants and compare helpers for the 3x3 median filter.
package mf3_pkg;

    // Line store depth; widest row the block can take
    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    // Configuration register width and register indexes
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = CFG_IDX_W'(1);

    // Smallest frame dimension the filter handles
    localparam int MIN_DIM = 3;

    // Result queue; depth must be a power of two so the pointers wrap
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    typedef logic [7:0] pix_t;

    typedef struct packed {
        logic kind;
        pix_t sample;
    } item_t;

    typedef struct packed {
        pix_t filtered;
        logic run_last;
        logic frame_last;
    } result_t;

    // One window column: rows r-2, r-1, r
    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } col_t;

    // The same column in ascending order
    typedef struct packed {
        pix_t lo;
        pix_t md;
        pix_t hi;
    } sorted_t;

    // One line store entry: the two previous rows at one column
    typedef struct packed {
        pix_t upper;
        pix_t middle;
    } line_pair_t;

    // Line store port controls
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        line_pair_t        wr_data;
    } ls_ctl_t;

    // Up to two results pushed into the queue in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        result_t    first;
        result_t    second;
    } q_push_t;

    // Per-request control carried down the pipeline
    typedef struct packed {
        logic       shift;
        logic       flush;
        logic       emit;
        logic       border;
        logic       row_end;
        logic       last;
        logic [1:0] nres;
    } pipe_ctl_t;

    // Three-way compare-exchange sort
    function automatic sorted_t sort3(input col_t c);
        pix_t x;
        pix_t y;
        pix_t z;
        pix_t t;
        sorted_t s;
        x = c.top;
        y = c.mid;
        z = c.bot;
        if (x > y)
        begin
            t = x; x = y; y = t;
        end
        if (y > z)
        begin
            t = y; y = z; z = t;
        end
        if (x > y)
        begin
            t = x; x = y; y = t;
        end
        s.lo = x;
        s.md = y;
        s.hi = z;
        return s;
    endfunction

    function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
        pix_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
        pix_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        pix_t hi_ab;
        pix_t lo_ab;
        hi_ab = (a > b) ? a : b;
        lo_ab = (a > b) ? b : a;
        if (c >= hi_ab)
            return hi_ab;
        else if (c <= lo_ab)
            return lo_ab;
        else
            return c;
    endfunction

endpackage

/* rtl/mf3_line_store.sv */
// Paired line store holding the two previous rows, registered read.
module mf3_line_store (
    input  logic              clk,
    input  mf3_pkg::ls_ctl_t  ctl,
    output mf3_pkg::line_pair_t rd_data
);
    import mf3_pkg::*;

    line_pair_t mem [MAX_WIDTH];
    line_pair_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            mem[ctl.wr_addr] <= ctl.wr_data;
    end

    // read port, data registered and ready the cycle after the address
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
            rd_data_reg <= mem[ctl.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/mf3_column_cell.sv */
// One window column cell: holds a raw column and its sorted form.
module mf3_column_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  mf3_pkg::col_t     col_in,
    output mf3_pkg::col_t     col,
    output mf3_pkg::sorted_t  srt
);
    import mf3_pkg::*;

    col_t    col_reg;
    sorted_t srt_reg;
    sorted_t srt_next;

    // sort the column as it enters
    always_comb
    begin
        srt_next = sort3(col_in);
    end

    // take the neighbour's column on every shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            srt_reg <= '0;
        end
        else if (shift)
        begin
            col_reg <= col_in;
            srt_reg <= srt_next;
        end
    end

    assign col = col_reg;
    assign srt = srt_reg;

endmodule

/* rtl/mf3_result_fifo.sv */
// Result queue taking up to two results per cycle, one out per cycle.
module mf3_result_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mf3_pkg::q_push_t          push,
    input  logic                      pop,
    output logic                      valid,
    output mf3_pkg::result_t          head,
    output logic [mf3_pkg::QCNT_W-1:0] count
);
    import mf3_pkg::*;

    result_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic [QPTR_W-1:0]   wr_ptr_inc;

    assign wr_ptr_inc = QPTR_W'(wr_ptr_reg + 1'b1);

    // storage
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.cnt == 2'd2)
            mem[wr_ptr_inc] <= push.second;
    end

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = QPTR_W'(wr_ptr_reg + QPTR_W'(push.cnt));
        rd_ptr_next = QPTR_W'(rd_ptr_reg + QPTR_W'(pop));
        count_next  = QCNT_W'(count_reg + QCNT_W'(push.cnt) - QCNT_W'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign valid = (count_reg != '0);
    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

/* rtl/median_filter_3x3.sv */
// Top level of the streaming 3x3 median filter.
// Takes one request per clock, sustained, as long as results are taken at the same pace:
// a sample request reads both line stores together, shifts the new column into a chain
// of three column cells the next cycle and has its results in the 8-entry result queue
// in the cycle after. Requests are stalled only while the queue cannot hold every result
// still on its way plus two more. Results run one row and one column behind the input;
// first and last rows and columns pass through unchanged, and the last row of a frame
// comes out one sample per flush request. The two line stores share one memory with one
// read and one write port; a read and a write never meet at the same address, since a
// row is at least three columns wide.
module median_filter_3x3 (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  mf3_pkg::item_t              item,
    output logic                        result_valid,
    input  logic                        result_stall,
    output mf3_pkg::result_t            result,
    input  logic                        cfg_write,
    input  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mf3_pkg::CFG_W-1:0]   cfg_data
);
    import mf3_pkg::*;

    localparam int RES_W = QCNT_W + 2;

    // configuration
    logic [CFG_W-1:0]  line_width_reg;
    logic [CFG_W-1:0]  row_count_reg;

    // frame position
    logic [ADDR_W-1:0] column_pos_reg;
    logic [ADDR_W-1:0] column_pos_next;
    logic [CFG_W-1:0]  row_pos_reg;
    logic [CFG_W-1:0]  row_pos_next;
    logic [ADDR_W-1:0] flush_pos_reg;
    logic [ADDR_W-1:0] flush_pos_next;

    // request stage
    logic [ADDR_W-1:0] last_col;
    logic [CFG_W-1:0]  rows_eff;
    logic              pending;
    logic [ADDR_W-1:0] col_sel;
    logic              row_end;
    logic              flush_last;
    logic [CFG_W:0]    row_inc;
    logic [CFG_W-1:0]  row_sat;
    logic              accept;
    logic              act_sample;
    logic              act_flush;
    pipe_ctl_t         a_ctl;
    ls_ctl_t           ls_ctl;

    // read stage
    pipe_ctl_t         b_ctl_reg;
    logic [ADDR_W-1:0] b_addr_reg;
    pix_t              b_sample_reg;
    line_pair_t        ls_rd;
    col_t              new_col;

    // window stage
    pipe_ctl_t         c_ctl_reg;
    pix_t              c_flush_val_reg;
    col_t              cell_col [3];
    sorted_t           cell_srt [3];
    pix_t              median;
    q_push_t           q_push;

    // result queue
    logic [QCNT_W-1:0] q_count;
    logic [RES_W-1:0]  reserve;
    logic              q_pop;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= CFG_W'(640);
            row_count_reg  <= CFG_W'(480);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LINE_WIDTH: line_width_reg <= cfg_data;
                REG_ROW_COUNT:  row_count_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // room for every result in flight plus two more
    assign reserve = RES_W'(q_count) + RES_W'(b_ctl_reg.nres) + RES_W'(c_ctl_reg.nres)
                     + RES_W'(2);
    assign item_stall = (reserve > RES_W'(QUEUE_DEPTH));
    assign accept     = item_valid && !item_stall;

    // request decode and position bookkeeping
    always_comb
    begin
        // clamped last column and row count
        if (line_width_reg < CFG_W'(MIN_DIM))
            last_col = ADDR_W'(MIN_DIM - 1);
        else if (32'(line_width_reg) > MAX_WIDTH)
            last_col = ADDR_W'(MAX_WIDTH - 1);
        else
            last_col = ADDR_W'(line_width_reg - 1'b1);
        rows_eff = (row_count_reg < CFG_W'(MIN_DIM)) ? CFG_W'(MIN_DIM) : row_count_reg;

        pending    = (row_pos_reg >= rows_eff);
        col_sel    = (column_pos_reg >= last_col) ? last_col : column_pos_reg;
        row_end    = (col_sel == last_col);
        flush_last = (flush_pos_reg >= last_col);
        row_inc    = {1'b0, row_pos_reg} + 1'b1;
        row_sat    = (row_inc >= {1'b0, rows_eff}) ? rows_eff : row_inc[CFG_W-1:0];

        act_sample = accept && !pending && (item.kind == KIND_SAMPLE);
        act_flush  = accept && pending && (item.kind == KIND_FLUSH);

        a_ctl         = '0;
        a_ctl.shift   = act_sample;
        a_ctl.flush   = act_flush;
        a_ctl.emit    = act_sample && (row_pos_reg != '0) && (col_sel != '0);
        a_ctl.border  = (row_pos_reg == CFG_W'(1)) || (col_sel == ADDR_W'(1));
        a_ctl.row_end = row_end;
        a_ctl.last    = flush_last;
        if (act_flush)
            a_ctl.nres = 2'd1;
        else if (a_ctl.emit)
            a_ctl.nres = row_end ? 2'd2 : 2'd1;
        else
            a_ctl.nres = 2'd0;

        column_pos_next = column_pos_reg;
        row_pos_next    = row_pos_reg;
        flush_pos_next  = flush_pos_reg;
        if (act_sample)
        begin
            if (row_end)
            begin
                column_pos_next = '0;
                row_pos_next    = row_sat;
                flush_pos_next  = '0;
            end
            else
            begin
                column_pos_next = ADDR_W'(col_sel + 1'b1);
            end
        end
        else if (act_flush)
        begin
            if (flush_last)
            begin
                column_pos_next = '0;
                row_pos_next    = '0;
                flush_pos_next  = '0;
            end
            else
            begin
                flush_pos_next = ADDR_W'(flush_pos_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_pos_reg <= '0;
            row_pos_reg    <= '0;
            flush_pos_reg  <= '0;
        end
        else
        begin
            column_pos_reg <= column_pos_next;
            row_pos_reg    <= row_pos_next;
            flush_pos_reg  <= flush_pos_next;
        end
    end

    // line store: read on request, write back the cycle after
    always_comb
    begin
        ls_ctl.rd_en          = act_sample || act_flush;
        ls_ctl.rd_addr        = act_flush ? flush_pos_reg : col_sel;
        ls_ctl.wr_en          = b_ctl_reg.shift;
        ls_ctl.wr_addr        = b_addr_reg;
        ls_ctl.wr_data.upper  = ls_rd.middle;
        ls_ctl.wr_data.middle = b_sample_reg;
    end

    mf3_line_store u_line_store (
        .clk     (clk),
        .ctl     (ls_ctl),
        .rd_data (ls_rd)
    );

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_ctl_reg <= '0;
            c_ctl_reg <= '0;
        end
        else
        begin
            b_ctl_reg <= a_ctl;
            c_ctl_reg <= b_ctl_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        b_addr_reg      <= col_sel;
        b_sample_reg    <= item.sample;
        c_flush_val_reg <= ls_rd.middle;
    end

    // column cell chain, newest column on the right
    assign new_col.top = ls_rd.upper;
    assign new_col.mid = ls_rd.middle;
    assign new_col.bot = b_sample_reg;

    mf3_column_cell u_cell_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .shift  (b_ctl_reg.shift),
        .col_in (new_col),
        .col    (cell_col[2]),
        .srt    (cell_srt[2])
    );

    mf3_column_cell u_cell_centre (
        .clk    (clk),
        .rst_n  (rst_n),
        .shift  (b_ctl_reg.shift),
        .col_in (cell_col[2]),
        .col    (cell_col[1]),
        .srt    (cell_srt[1])
    );

    mf3_column_cell u_cell_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .shift  (b_ctl_reg.shift),
        .col_in (cell_col[1]),
        .col    (cell_col[0]),
        .srt    (cell_srt[0])
    );

    // median of nine from the sorted columns
    assign median = med3(max3(cell_srt[0].lo, cell_srt[1].lo, cell_srt[2].lo),
                         med3(cell_srt[0].md, cell_srt[1].md, cell_srt[2].md),
                         min3(cell_srt[0].hi, cell_srt[1].hi, cell_srt[2].hi));

    // results into the queue
    always_comb
    begin
        q_push = '0;
        q_push.cnt = c_ctl_reg.nres;
        if (c_ctl_reg.flush)
        begin
            q_push.first.filtered   = c_flush_val_reg;
            q_push.first.run_last   = 1'b1;
            q_push.first.frame_last = c_ctl_reg.last;
        end
        else
        begin
            q_push.first.filtered    = c_ctl_reg.border ? cell_col[1].mid : median;
            q_push.first.run_last    = !c_ctl_reg.row_end;
            q_push.first.frame_last  = 1'b0;
            q_push.second.filtered   = cell_col[2].mid;
            q_push.second.run_last   = 1'b1;
            q_push.second.frame_last = 1'b0;
        end
    end

    assign q_pop = result_valid && !result_stall;

    mf3_result_fifo u_result_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .pop   (q_pop),
        .valid (result_valid),
        .head  (result),
        .count (q_count)
    );

`ifndef ASSERT_OFF
    // results in flight never exceed the queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (RES_W'(q_count) + RES_W'(b_ctl_reg.nres) + RES_W'(c_ctl_reg.nres))
            <= RES_W'(QUEUE_DEPTH))
        else $error("result queue over-committed");

    // line store read and write never collide
    a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ls_ctl.rd_en && ls_ctl.wr_en) |-> (ls_ctl.rd_addr != ls_ctl.wr_addr))
        else $error("line store read and write at the same address");

    // a request that ends the frame leaves all positions at zero
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (act_flush && flush_last) |=>
            (row_pos_reg == '0) && (column_pos_reg == '0) && (flush_pos_reg == '0))
        else $error("positions not cleared at end of frame");
`endif

endmodule
